@@ rtl/core/ddo_pkg.sv @@
// Shared types, constants, microcode format and sine table for the odometry block.
`timescale 1ns / 1ps

package ddo_pkg;

	// Sine table resolution: a full turn is split into 2^SINE_TABLE_BITS steps.
	localparam int SINE_TABLE_BITS = 10;
	localparam int QTR_STEPS       = 1 << (SINE_TABLE_BITS - 2);
	localparam int QIDX_W          = SINE_TABLE_BITS - 1;

	localparam int HEAD_W  = 24;
	localparam int POS_W   = 40;
	localparam int TOTAL_W = 32;
	localparam int PROD_W  = 34;
	localparam int TRIG_W  = 17;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [15:0] GAIN_RESET  = 16'd668;

	typedef logic [QIDX_W-1:0] qidx_t;
	typedef logic [15:0] qsin_tab_t [0:QTR_STEPS];

	typedef logic [3:0] step_t;

	localparam step_t ST_WAIT  = 4'd0;
	localparam step_t ST_TURN  = 4'd1;
	localparam step_t ST_HALF  = 4'd2;
	localparam step_t ST_COS   = 4'd3;
	localparam step_t ST_MULX  = 4'd4;
	localparam step_t ST_ADDX  = 4'd5;
	localparam step_t ST_ADDY  = 4'd6;
	localparam step_t ST_SET   = 4'd7;
	localparam step_t ST_OUT   = 4'd8;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_SET  = 1'b1;

	typedef enum logic [2:0] {
		JMP_NEXT,
		JMP_WAIT_IN,
		JMP_CMD,
		JMP_GOTO,
		JMP_OUT
	} jmp_t;

	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_TURN,
		MUL_MOVE
	} mul_t;

	typedef enum logic [1:0] {
		TRIG_NONE,
		TRIG_COS,
		TRIG_SIN
	} trig_t;

	// Datapath enables for one step.
	typedef struct packed {
		logic  load_in;
		mul_t  mul;
		logic  totals;
		logic  hd_half1;
		logic  hd_rem;
		trig_t trig;
		logic  x_add;
		logic  y_add;
		logic  set_pose;
		logic  out_load;
	} ctrl_t;

	typedef struct packed {
		jmp_t  jmp;
		step_t target;
		ctrl_t ops;
	} ucode_t;

	// One Taylor step: term * x^2 in Q30, floored at each multiply.
	function automatic logic [63:0] qsin_term(input logic [63:0] term, input logic [63:0] x);
		qsin_term = (((term * x) >> 30) * x) >> 30;
	endfunction

	// Quarter-wave sine magnitude at step k, Q15, clamped to [0, 32768].
	function automatic logic [15:0] qsin_value(input logic [63:0] k);
		logic [63:0]        x;
		logic [63:0]        t;
		logic signed [63:0] acc;
		logic [63:0]        r;
		x   = (k * HALF_PI_Q30) >> (SINE_TABLE_BITS - 2);
		t   = x;
		acc = signed'(x);
		t = qsin_term(t, x) / 64'd6;   acc = acc - signed'(t);
		t = qsin_term(t, x) / 64'd20;  acc = acc + signed'(t);
		t = qsin_term(t, x) / 64'd42;  acc = acc - signed'(t);
		t = qsin_term(t, x) / 64'd72;  acc = acc + signed'(t);
		t = qsin_term(t, x) / 64'd110; acc = acc - signed'(t);
		t = qsin_term(t, x) / 64'd156; acc = acc + signed'(t);
		t = qsin_term(t, x) / 64'd210; acc = acc - signed'(t);
		t = qsin_term(t, x) / 64'd272; acc = acc + signed'(t);
		if (acc < 0) begin
			acc = 64'sd0;
		end
		r = (unsigned'(acc) + 64'd16384) >> 15;
		if (r > 64'd32768) begin
			r = 64'd32768;
		end
		return r[15:0];
	endfunction

	function automatic qsin_tab_t qsin_build();
		qsin_tab_t tab;
		for (int k = 0; k <= QTR_STEPS; k++) begin
			tab[k] = qsin_value(64'(k));
		end
		return tab;
	endfunction

	localparam qsin_tab_t QSIN_TABLE = qsin_build();

endpackage

@@ rtl/core/ddo_useq.sv @@
// Microcode sequencer: step counter, control store and handshake control.
`timescale 1ns / 1ps

module ddo_useq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  logic           cmd_q,
	output ddo_pkg::ctrl_t ctrl
);

	ddo_pkg::step_t  step_q;
	ddo_pkg::step_t  step_nxt;
	ddo_pkg::ucode_t uw;
	logic            in_fire;
	logic            slot_free;
	logic            out_valid_q;

	function automatic ddo_pkg::ucode_t ucode_rom(input ddo_pkg::step_t s);
		ddo_pkg::ucode_t w;
		w            = '0;
		w.jmp        = ddo_pkg::JMP_NEXT;
		w.target     = ddo_pkg::ST_WAIT;
		w.ops.mul    = ddo_pkg::MUL_NONE;
		w.ops.trig   = ddo_pkg::TRIG_NONE;
		case (s)
			ddo_pkg::ST_WAIT: begin
				w.jmp         = ddo_pkg::JMP_WAIT_IN;
				w.ops.load_in = 1'b1;
			end
			ddo_pkg::ST_TURN: begin
				w.jmp        = ddo_pkg::JMP_CMD;
				w.target     = ddo_pkg::ST_SET;
				w.ops.mul    = ddo_pkg::MUL_TURN;
				w.ops.totals = 1'b1;
			end
			ddo_pkg::ST_HALF: begin
				w.ops.hd_half1 = 1'b1;
			end
			ddo_pkg::ST_COS: begin
				w.ops.trig = ddo_pkg::TRIG_COS;
			end
			ddo_pkg::ST_MULX: begin
				w.ops.mul  = ddo_pkg::MUL_MOVE;
				w.ops.trig = ddo_pkg::TRIG_SIN;
			end
			ddo_pkg::ST_ADDX: begin
				w.ops.x_add  = 1'b1;
				w.ops.mul    = ddo_pkg::MUL_MOVE;
				w.ops.hd_rem = 1'b1;
			end
			ddo_pkg::ST_ADDY: begin
				w.jmp       = ddo_pkg::JMP_GOTO;
				w.target    = ddo_pkg::ST_OUT;
				w.ops.y_add = 1'b1;
			end
			ddo_pkg::ST_SET: begin
				w.jmp          = ddo_pkg::JMP_GOTO;
				w.target       = ddo_pkg::ST_OUT;
				w.ops.set_pose = 1'b1;
			end
			ddo_pkg::ST_OUT: begin
				w.jmp          = ddo_pkg::JMP_OUT;
				w.target       = ddo_pkg::ST_WAIT;
				w.ops.out_load = 1'b1;
			end
			default: begin
				w.jmp = ddo_pkg::JMP_GOTO;
			end
		endcase
		return w;
	endfunction

	always_comb begin
		uw        = ucode_rom(step_q);
		in_ready  = (uw.jmp == ddo_pkg::JMP_WAIT_IN);
		in_fire   = in_valid && in_ready;
		slot_free = !out_valid_q || out_ready;

		ctrl          = uw.ops;
		ctrl.load_in  = uw.ops.load_in && in_fire;
		ctrl.out_load = uw.ops.out_load && slot_free;

		case (uw.jmp)
			ddo_pkg::JMP_NEXT:    step_nxt = step_q + 4'd1;
			ddo_pkg::JMP_WAIT_IN: step_nxt = in_fire ? step_q + 4'd1 : step_q;
			ddo_pkg::JMP_CMD:     step_nxt = (cmd_q == ddo_pkg::CMD_SET) ? uw.target
				: step_q + 4'd1;
			ddo_pkg::JMP_GOTO:    step_nxt = uw.target;
			ddo_pkg::JMP_OUT:     step_nxt = slot_free ? uw.target : step_q;
			default:              step_nxt = ddo_pkg::ST_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ddo_pkg::ST_WAIT;
			out_valid_q <= 1'b0;
		end else begin
			step_q <= step_nxt;
			if (ctrl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/core/ddo_dpath.sv @@
// Odometry datapath: pose state, shared multiplier, sine lookup and result register.
`timescale 1ns / 1ps

module ddo_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  ddo_pkg::ctrl_t     ctrl,
	input  logic               cfg_valid,
	input  logic [15:0]        cfg_data,
	input  logic               cmd,
	input  logic signed [15:0] delta_left,
	input  logic signed [15:0] delta_right,
	input  logic signed [31:0] set_x,
	input  logic signed [31:0] set_y,
	input  logic [15:0]        set_heading,
	output logic               cmd_q,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic [15:0]        heading_out,
	output logic signed [31:0] left_distance,
	output logic signed [31:0] right_distance
);

	logic [15:0]                           gain_q;
	logic signed [15:0]                    dl_q;
	logic signed [15:0]                    dr_q;
	logic signed [31:0]                    sx_q;
	logic signed [31:0]                    sy_q;
	logic [15:0]                           sh_q;

	logic [ddo_pkg::POS_W-1:0]             x_q;
	logic [ddo_pkg::POS_W-1:0]             y_q;
	logic [ddo_pkg::HEAD_W-1:0]            hd_q;
	logic [ddo_pkg::TOTAL_W-1:0]           lt_q;
	logic [ddo_pkg::TOTAL_W-1:0]           rt_q;
	logic [ddo_pkg::HEAD_W-1:0]            rem_q;
	logic signed [ddo_pkg::PROD_W-1:0]     prod_q;
	logic signed [ddo_pkg::TRIG_W-1:0]     trig_q;

	logic signed [16:0]                    wsum;
	logic signed [16:0]                    wdiff;
	logic signed [16:0]                    mul_a;
	logic signed [ddo_pkg::TRIG_W-1:0]     mul_b;
	logic [ddo_pkg::HEAD_W-1:0]            half1;
	logic [ddo_pkg::HEAD_W-1:0]            half2;
	logic [ddo_pkg::POS_W-1:0]             move;
	logic [ddo_pkg::SINE_TABLE_BITS-1:0]   tidx;
	ddo_pkg::qidx_t                        qidx;
	logic [15:0]                           mag;
	logic signed [ddo_pkg::TRIG_W-1:0]     trig_val;

	function automatic logic signed [16:0] delta_sext(input logic signed [15:0] d);
		return 17'(d);
	endfunction

	always_comb begin
		wsum  = 17'(delta_sext(dl_q)) + 17'(delta_sext(dr_q));
		wdiff = 17'(delta_sext(dr_q)) - 17'(delta_sext(dl_q));

		if (ctrl.mul == ddo_pkg::MUL_TURN) begin
			mul_a = wdiff;
			mul_b = signed'({1'b0, gain_q});
		end else begin
			mul_a = wsum;
			mul_b = trig_q;
		end

		// Floor of half the turn, then the rest, so the whole turn lands exactly.
		half1 = prod_q[ddo_pkg::HEAD_W:1];
		half2 = prod_q[ddo_pkg::HEAD_W-1:0] - half1;

		// Travel is the wheel sum times 128, so the Q15 product shifts by 8 only.
		move = {{(ddo_pkg::POS_W - (ddo_pkg::PROD_W - 8)){prod_q[ddo_pkg::PROD_W-1]}},
			prod_q[ddo_pkg::PROD_W-1:8]};

		tidx = hd_q[ddo_pkg::HEAD_W-1 -: ddo_pkg::SINE_TABLE_BITS];
		if (ctrl.trig == ddo_pkg::TRIG_COS) begin
			tidx = tidx + ddo_pkg::SINE_TABLE_BITS'(ddo_pkg::QTR_STEPS);
		end
		// Odd quadrants read the quarter wave mirrored.
		if (tidx[ddo_pkg::SINE_TABLE_BITS-2]) begin
			qidx = ddo_pkg::QIDX_W'(ddo_pkg::QTR_STEPS)
				- {1'b0, tidx[ddo_pkg::SINE_TABLE_BITS-3:0]};
		end else begin
			qidx = {1'b0, tidx[ddo_pkg::SINE_TABLE_BITS-3:0]};
		end
		mag = ddo_pkg::QSIN_TABLE[qidx];
		if (tidx[ddo_pkg::SINE_TABLE_BITS-1]) begin
			trig_val = -signed'({1'b0, mag});
		end else begin
			trig_val = signed'({1'b0, mag});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= ddo_pkg::GAIN_RESET;
			x_q    <= '0;
			y_q    <= '0;
			hd_q   <= '0;
			lt_q   <= '0;
			rt_q   <= '0;
		end else begin
			if (cfg_valid) begin
				gain_q <= cfg_data;
			end
			if (ctrl.totals && (cmd_q == ddo_pkg::CMD_TICK)) begin
				lt_q <= lt_q + ddo_pkg::TOTAL_W'(dl_q);
				rt_q <= rt_q + ddo_pkg::TOTAL_W'(dr_q);
			end
			if (ctrl.set_pose) begin
				x_q  <= {sx_q, 8'h00};
				y_q  <= {sy_q, 8'h00};
				hd_q <= {sh_q, 8'h00};
			end else begin
				if (ctrl.x_add) begin
					x_q <= x_q + move;
				end
				if (ctrl.y_add) begin
					y_q <= y_q + move;
				end
				if (ctrl.hd_half1) begin
					hd_q <= hd_q + half1;
				end else if (ctrl.hd_rem) begin
					hd_q <= hd_q + rem_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_in) begin
			cmd_q <= cmd;
			dl_q  <= delta_left;
			dr_q  <= delta_right;
			sx_q  <= set_x;
			sy_q  <= set_y;
			sh_q  <= set_heading;
		end
		if (ctrl.mul != ddo_pkg::MUL_NONE) begin
			prod_q <= ddo_pkg::PROD_W'(mul_a * mul_b);
		end
		if (ctrl.hd_half1) begin
			rem_q <= half2;
		end
		if (ctrl.trig != ddo_pkg::TRIG_NONE) begin
			trig_q <= trig_val;
		end
		if (ctrl.out_load) begin
			pos_x          <= signed'(x_q[ddo_pkg::POS_W-1:8]);
			pos_y          <= signed'(y_q[ddo_pkg::POS_W-1:8]);
			heading_out    <= hd_q[ddo_pkg::HEAD_W-1:8];
			left_distance  <= signed'(lt_q);
			right_distance <= signed'(rt_q);
		end
	end

endmodule

@@ rtl/core/differential_drive_odometry.sv @@
// Top level of the differential-drive dead-reckoning odometry block.
`timescale 1ns / 1ps

// Tracks the pose of a two-wheeled robot from wheel travel reports.
// The input channel (in_valid/in_ready) carries one item per transfer: cmd 0 is an
// odometry tick with delta_left and delta_right, cmd 1 loads set_x, set_y and
// set_heading. Every item gives exactly one result on the output channel
// (out_valid/out_ready): position, heading and both wheel totals after the item.
// The configuration channel (cfg_valid/cfg_ready/cfg_data) writes heading_gain;
// it is always ready and should be written only while the block is idle.
// A short microprogram runs each item on one shared 17x17 multiplier and one
// sine table: a tick steps through TURN, HALF, COS, MULX, ADDX, ADDY and OUT
// after its transfer, a set-pose item through TURN, SET and OUT. The next item
// is taken on the cycle after the result is loaded: one item is in work at a time.
// The result register is separate from the pose state, so a stalled receiver
// does not stop work on the following item; only the final load waits for it.
// Reset clears the pose, the totals and the output channel, and sets
// heading_gain to 668.

module differential_drive_odometry (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic signed [15:0] delta_left,
	input  logic signed [15:0] delta_right,
	input  logic signed [31:0] set_x,
	input  logic signed [31:0] set_y,
	input  logic [15:0]        set_heading,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic [15:0]        heading_out,
	output logic signed [31:0] left_distance,
	output logic signed [31:0] right_distance
);

	ddo_pkg::ctrl_t ctrl;
	logic           cmd_q;

	assign cfg_ready = 1'b1;

	ddo_useq u_useq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd_q     (cmd_q),
		.ctrl      (ctrl)
	);

	ddo_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.cfg_valid      (cfg_valid),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.delta_left     (delta_left),
		.delta_right    (delta_right),
		.set_x          (set_x),
		.set_y          (set_y),
		.set_heading    (set_heading),
		.cmd_q          (cmd_q),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.heading_out    (heading_out),
		.left_distance  (left_distance),
		.right_distance (right_distance)
	);

`ifndef SYNTHESIS
	// A pending result is never overwritten by the next one.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load |-> (!out_valid || out_ready))
		else $error("result register loaded while a result was pending");

	// One item at a time: after a transfer the input stays closed.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted again right after a transfer");

	// Only one position update per step.
	a_pos_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctrl.x_add, ctrl.y_add, ctrl.set_pose}))
		else $error("conflicting position updates");

	// Input is never taken while the microprogram is mid-item.
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load_in |-> (!ctrl.out_load && ctrl.mul == ddo_pkg::MUL_NONE))
		else $error("input loaded during item processing");
`endif

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the differential-drive odometry block.
`timescale 1ns / 1ps

module tb_top;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic               op;
		logic signed [15:0] dl;
		logic signed [15:0] dr;
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic [15:0]        sh;
	} odo_item_t;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [15:0]        heading;
		logic signed [31:0] left;
		logic signed [31:0] right;
	} pose_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic               cmd;
	logic signed [15:0] delta_left;
	logic signed [15:0] delta_right;
	logic signed [31:0] set_x;
	logic signed [31:0] set_y;
	logic [15:0]        set_heading;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic [15:0]        heading_out;
	logic signed [31:0] left_distance;
	logic signed [31:0] right_distance;

	// Predicted pose state and register copy.
	logic [39:0] est_x;
	logic [39:0] est_y;
	logic [23:0] est_heading;
	logic [31:0] est_left;
	logic [31:0] est_right;
	logic [15:0] est_gain;

	pose_t       expected_poses[$];
	int unsigned in_idle_pct;
	int unsigned out_idle_pct;
	int unsigned hold_request;
	int unsigned mismatch_count;
	int unsigned results_checked;
	int unsigned tick_count;
	int unsigned set_count;
	int unsigned gain_writes;
	int unsigned cycle_count;

	differential_drive_odometry dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.cmd            (cmd),
		.delta_left     (delta_left),
		.delta_right    (delta_right),
		.set_x          (set_x),
		.set_y          (set_y),
		.set_heading    (set_heading),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.heading_out    (heading_out),
		.left_distance  (left_distance),
		.right_distance (right_distance)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Quarter-wave sine magnitude in Q15 from a floored integer Taylor series in Q30.
	function automatic longint quarter_wave(input int unsigned k);
		logic [63:0] ang;
		logic [63:0] term;
		longint      acc;
		logic [63:0] rounded;
		ang  = (64'(k) * ddo_pkg::HALF_PI_Q30) / 64'(ddo_pkg::QTR_STEPS);
		term = ang;
		acc  = longint'(ang);
		for (int n = 1; n <= 8; n++) begin
			term = (((term * ang) >> 30) * ang) >> 30;
			term = term / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		rounded = (64'(acc) + 64'd16384) >> 15;
		if (rounded > 64'd32768) begin
			rounded = 64'd32768;
		end
		return longint'(rounded);
	endfunction

	function automatic longint full_wave(input logic [ddo_pkg::SINE_TABLE_BITS-1:0] idx);
		int unsigned quad;
		int unsigned w;
		quad = idx >> (ddo_pkg::SINE_TABLE_BITS - 2);
		w    = idx & (ddo_pkg::QTR_STEPS - 1);
		case (quad)
			0: return quarter_wave(w);
			1: return quarter_wave(ddo_pkg::QTR_STEPS - w);
			2: return -quarter_wave(w);
			default: return -quarter_wave(ddo_pkg::QTR_STEPS - w);
		endcase
	endfunction

	// Applies one item to the predicted state and returns the pose it reports.
	function automatic pose_t apply_item(input odo_item_t it);
		longint                              dl;
		longint                              dr;
		longint                              turn;
		longint                              first_half;
		longint                              travel;
		longint                              cosv;
		longint                              sinv;
		logic [ddo_pkg::SINE_TABLE_BITS-1:0] idx;
		pose_t                               p;
		if (it.op == ddo_pkg::CMD_SET) begin
			est_x       = {it.sx, 8'h00};
			est_y       = {it.sy, 8'h00};
			est_heading = {it.sh, 8'h00};
		end else begin
			dl         = it.dl;
			dr         = it.dr;
			turn       = (dr - dl) * longint'(est_gain);
			first_half = turn >>> 1;
			travel     = (dl + dr) * 128;
			est_left   = est_left + 32'(dl);
			est_right  = est_right + 32'(dr);
			// Move along the midpoint heading, then finish the turn.
			est_heading = est_heading + 24'(first_half);
			idx         = est_heading[23 -: ddo_pkg::SINE_TABLE_BITS];
			cosv        = full_wave(idx + ddo_pkg::SINE_TABLE_BITS'(ddo_pkg::QTR_STEPS));
			sinv        = full_wave(idx);
			est_x       = est_x + 40'((travel * cosv) >>> 15);
			est_y       = est_y + 40'((travel * sinv) >>> 15);
			est_heading = est_heading + 24'(turn - first_half);
		end
		p.x       = est_x[39:8];
		p.y       = est_y[39:8];
		p.heading = est_heading[23:8];
		p.left    = est_left;
		p.right   = est_right;
		return p;
	endfunction

	function automatic logic signed [15:0] random_delta();
		int unsigned pick;
		pick = $urandom_range(0, 3);
		if (pick < 2) begin
			return 16'($urandom_range(0, 128) - 64);
		end else if (pick == 2) begin
			return 16'($urandom_range(0, 4096) - 2048);
		end
		return 16'($urandom);
	endfunction

	function automatic odo_item_t tick_item(input int l, input int r);
		odo_item_t it;
		it.op = ddo_pkg::CMD_TICK;
		it.dl = 16'(l);
		it.dr = 16'(r);
		it.sx = $urandom;
		it.sy = $urandom;
		it.sh = 16'($urandom);
		return it;
	endfunction

	function automatic odo_item_t pose_item(input logic [31:0] sx, input logic [31:0] sy,
			input logic [15:0] sh);
		odo_item_t it;
		it.op = ddo_pkg::CMD_SET;
		it.dl = 16'($urandom);
		it.dr = 16'($urandom);
		it.sx = sx;
		it.sy = sy;
		it.sh = sh;
		return it;
	endfunction

	function automatic odo_item_t random_item();
		odo_item_t it;
		if ($urandom_range(0, 99) < 15) begin
			it = pose_item($urandom, $urandom, 16'($urandom));
		end else begin
			it = tick_item(0, 0);
			it.dl = random_delta();
			it.dr = random_delta();
		end
		return it;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
		end
	endtask

	// Offers one item, holding it until the transfer, then records its prediction.
	task automatic send_item(input odo_item_t it);
		@(negedge clk);
		while ($urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		cmd         <= it.op;
		delta_left  <= it.dl;
		delta_right <= it.dr;
		set_x       <= it.sx;
		set_y       <= it.sy;
		set_heading <= it.sh;
		do @(posedge clk); while (!in_ready);
		expected_poses.push_back(apply_item(it));
		if (it.op == ddo_pkg::CMD_SET) begin
			set_count++;
		end else begin
			tick_count++;
		end
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_poses.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_gain(input logic [15:0] gain);
		wait_for_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= gain;
		do @(posedge clk); while (!cfg_ready);
		est_gain = gain;
		gain_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_directed();
		in_idle_pct  = 0;
		out_idle_pct = 0;
		send_item(tick_item(0, 0));
		send_item(tick_item(100, 100));
		send_item(tick_item(-100, 100));
		send_item(tick_item(32767, 32767));
		send_item(tick_item(-32768, -32768));
		send_item(tick_item(-32768, 32767));
		send_item(tick_item(32767, -32768));
		// Position wraps past the largest x, then past the largest y.
		send_item(pose_item(32'h7FFF_FFFF, 32'h8000_0000, 16'h0000));
		send_item(tick_item(32767, 32767));
		send_item(pose_item(32'h8000_0000, 32'h7FFF_FFFF, 16'h4000));
		send_item(tick_item(32767, 32767));
		// Heading wraps through zero.
		send_item(pose_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
		send_item(tick_item(1, 3));
		send_item(pose_item(32'h0000_0000, 32'h0000_0000, 16'h8000));
		send_item(tick_item(-5, -5));
		send_item(pose_item(32'h0000_1234, 32'hFFFF_0000, 16'hC000));
		send_item(tick_item(7, 7));
		send_item(tick_item(-1, 0));
		send_item(pose_item(32'h5555_5555, 32'hAAAA_AAAA, 16'h2000));
		send_item(tick_item(1000, 1000));
		send_item(tick_item(-32768, -32767));
		wait_for_results();
	endtask

	task automatic test_gain_sweep();
		logic [15:0] gains[5];
		in_idle_pct  = 20;
		out_idle_pct = 20;
		gains = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom), ddo_pkg::GAIN_RESET};
		foreach (gains[g]) begin
			write_gain(gains[g]);
			send_item(tick_item(-32768, 32767));
			send_item(tick_item(32767, -32768));
			for (int i = 0; i < 6; i++) begin
				send_item(random_item());
			end
		end
		wait_for_results();
	endtask

	task automatic test_random_traffic();
		int unsigned send_pcts[3];
		int unsigned recv_pcts[3];
		logic [15:0] phase_gains[3];
		send_pcts   = '{37, 53, 0};
		recv_pcts   = '{53, 37, 0};
		phase_gains = '{16'($urandom), 16'($urandom_range(0, 2047)), ddo_pkg::GAIN_RESET};
		for (int ph = 0; ph < 3; ph++) begin
			write_gain(phase_gains[ph]);
			in_idle_pct  = send_pcts[ph];
			out_idle_pct = recv_pcts[ph];
			for (int i = 0; i < 110; i++) begin
				send_item(random_item());
			end
			wait_for_results();
		end
	endtask

	// The receiver stops for a long stretch so the block fills and stalls its input.
	task automatic test_output_backpressure();
		in_idle_pct  = 0;
		out_idle_pct = 0;
		hold_request = 300;
		for (int i = 0; i < 25; i++) begin
			send_item(random_item());
		end
		wait_for_results();
	endtask

	initial begin : receiver
		int unsigned hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : result_check
		pose_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_poses.size() == 0) begin
				report_mismatch("result transfer with no item outstanding");
			end else begin
				want = expected_poses.pop_front();
				check_field("pos_x", pos_x, want.x);
				check_field("pos_y", pos_y, want.y);
				check_field("heading_out", {16'h0000, heading_out}, {16'h0000, want.heading});
				check_field("left_distance", left_distance, want.left);
				check_field("right_distance", right_distance, want.right);
				results_checked++;
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped after %0d cycles without finishing.", cycle_count);
		$display("[differential_drive_odometry] ERROR");
		$finish;
	end

	initial begin
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		cmd         = ddo_pkg::CMD_TICK;
		delta_left  = '0;
		delta_right = '0;
		set_x       = '0;
		set_y       = '0;
		set_heading = '0;
		in_idle_pct     = 0;
		out_idle_pct    = 0;
		hold_request    = 0;
		mismatch_count  = 0;
		results_checked = 0;
		tick_count      = 0;
		set_count       = 0;
		gain_writes     = 0;
		est_x       = '0;
		est_y       = '0;
		est_heading = '0;
		est_left    = '0;
		est_right   = '0;
		est_gain    = ddo_pkg::GAIN_RESET;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_gain_sweep();
		test_random_traffic();
		test_output_backpressure();

		wait_for_results();
		repeat (20) @(posedge clk);
		if (expected_poses.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", expected_poses.size()));
		end
		$display("Sent %0d odometry ticks and %0d pose loads under %0d heading gain writes.",
			tick_count, set_count, gain_writes);
		$display("Checked %0d results; %0d mismatches.", results_checked, mismatch_count);
		if (mismatch_count == 0) begin
			$display("[differential_drive_odometry] OK");
		end else begin
			$display("[differential_drive_odometry] ERROR");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/ddo_pkg.sv
rtl/core/ddo_useq.sv
rtl/core/ddo_dpath.sv
rtl/core/differential_drive_odometry.sv
sim/tb_top.sv
